// ----- sv/assert_macros.svh -----
// Concurrent assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clk_i edge once rst_ni is released.
`define RGBH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clk_i edge, reset included.
`define RGBH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RGBH_ASSERT(lbl, prop, msg)
`define RGBH_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- sv/rgbh_pkg.sv -----
package rgbh_pkg;

  localparam int RGBH_LEVELS     = 4;
  localparam int RGBH_COUNT_BITS = 24;

  localparam int CH_W      = 8;
  localparam int FRAC_BITS = 16;
  localparam int PROP_W    = FRAC_BITS + 1;
  localparam int LABEL_W   = 7;

  // Bin memory commands issued by the controller.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_PIXEL,
    OP_READ,
    OP_CLEAR
  } rgbh_op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_DIV
  } rgbh_state_e;

endpackage

// ----- sv/rgbh_bin_mem.sv -----
`include "assert_macros.svh"

module rgbh_bin_mem
  import rgbh_pkg::*;
#(
  parameter int LEVELS     = RGBH_LEVELS,
  parameter int COUNT_BITS = RGBH_COUNT_BITS,
  parameter int NBINS      = LEVELS * LEVELS * LEVELS,
  parameter int BIN_W      = $clog2(NBINS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rgbh_op_e              op_i,
  input  logic [CH_W-1:0]       red_i,
  input  logic [CH_W-1:0]       green_i,
  input  logic [CH_W-1:0]       blue_i,
  input  logic [BIN_W-1:0]      addr_i,
  output logic [COUNT_BITS-1:0] rd_data_o
);

  localparam int STEP = 255 / LEVELS;
  localparam int LV_W = $clog2(LEVELS);

  logic [COUNT_BITS-1:0] mem [NBINS];

  logic [COUNT_BITS-1:0] rd_q;
  logic                  s1_v_q;
  logic [BIN_W-1:0]      s1_idx_q;
  logic                  wr_v_q;
  logic [BIN_W-1:0]      wr_idx_q;
  logic [COUNT_BITS-1:0] wr_data_q;

  logic                  re;
  logic [BIN_W-1:0]      raddr;
  logic                  clr;
  logic                  we;
  logic [BIN_W-1:0]      waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic [COUNT_BITS-1:0] old_cnt;
  logic [COUNT_BITS-1:0] inc_cnt;
  logic [BIN_W-1:0]      pix_idx;

  // Level = number of thresholds STEP*k (k = 1..LEVELS-1) the value exceeds.
  function automatic logic [LV_W-1:0] quant(input logic [CH_W-1:0] v);
    logic [LV_W-1:0] p;
    p = '0;
    for (int k = 1; k < LEVELS; k++) begin
      if (int'(v) > STEP * k) p = p + LV_W'(1);
    end
    return p;
  endfunction

  assign pix_idx = BIN_W'(quant(red_i)) * BIN_W'(LEVELS * LEVELS)
                 + BIN_W'(quant(green_i)) * BIN_W'(LEVELS)
                 + BIN_W'(quant(blue_i));

  always_comb begin
    re    = 1'b0;
    raddr = addr_i;
    clr   = 1'b0;
    unique case (op_i)
      OP_PIXEL: begin
        re    = 1'b1;
        raddr = pix_idx;
      end
      OP_READ:  re  = 1'b1;
      OP_CLEAR: clr = 1'b1;
      default: ;
    endcase
  end

  // Forward the previous write when it hit the bin that was read under it.
  assign old_cnt = (wr_v_q && (wr_idx_q == s1_idx_q)) ? wr_data_q : rd_q;
  assign inc_cnt = (&old_cnt) ? old_cnt : old_cnt + COUNT_BITS'(1);

  assign we    = s1_v_q | clr;
  assign waddr = s1_v_q ? s1_idx_q : addr_i;
  assign wdata = s1_v_q ? inc_cnt : '0;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (re) rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      wr_v_q <= 1'b0;
    end else begin
      s1_v_q <= (op_i == OP_PIXEL);
      if (s1_v_q) begin
        wr_v_q <= 1'b1;
      end else if (clr) begin
        wr_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_PIXEL) s1_idx_q <= pix_idx;
    if (s1_v_q) begin
      wr_idx_q  <= s1_idx_q;
      wr_data_q <= inc_cnt;
    end
  end

  assign rd_data_o = rd_q;

  `RGBH_ASSERT_ALWAYS(a_no_wr_clash, !(s1_v_q && clr), "pixel write collides with clear")
  `RGBH_ASSERT(a_fwd_tracks, s1_v_q |=> wr_v_q && (wr_idx_q == $past(s1_idx_q)), "write lost")
  `RGBH_ASSERT(a_clr_kills_fwd, (clr && !s1_v_q) |=> !wr_v_q, "forward reg valid after clear")

endmodule

// ----- sv/rgbh_div.sv -----
module rgbh_div
  import rgbh_pkg::*;
#(
  parameter int COUNT_BITS = RGBH_COUNT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic [COUNT_BITS-1:0] total_i,
  output logic                  busy_o,
  output logic [PROP_W-1:0]     quot_o
);

  // Dividend count*2^FRAC_BITS + total/2; quotient fits PROP_W bits.
  localparam int NW    = COUNT_BITS + PROP_W;
  localparam int STP_W = $clog2(PROP_W + 1);

  logic                  busy_q;
  logic [STP_W-1:0]      step_q;
  logic [COUNT_BITS-1:0] rem_q;
  logic [COUNT_BITS-1:0] den_q;
  logic [PROP_W-1:0]     low_q;
  logic [PROP_W-1:0]     quot_q;

  logic [NW-1:0]         num;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;

  assign num   = (NW'(count_i) << FRAC_BITS) + NW'(total_i >> 1);
  assign trial = {rem_q, low_q[PROP_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STP_W'(1);
      if (step_q == STP_W'(PROP_W - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num[NW-1:PROP_W];
      low_q <= num[PROP_W-1:0];
      den_q <= total_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      low_q  <= low_q << 1;
      quot_q <= {quot_q[PROP_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

// ----- sv/rgbh_top_placeholder_unused.sv -----
module rgbh_sat_cnt
  import rgbh_pkg::*;
#(
  parameter int COUNT_BITS = RGBH_COUNT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  inc_i,
  input  logic                  clr_i,
  output logic [COUNT_BITS-1:0] count_o
);

  // Pixel total: saturating increment, synchronous clear.
  logic [COUNT_BITS-1:0] count_q;
  logic [COUNT_BITS-1:0] count_d;

  always_comb begin
    count_d = count_q;
    if (clr_i) begin
      count_d = '0;
    end else if (inc_i && !(&count_q)) begin
      count_d = count_q + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

// ----- sv/rgb_color_histogram.sv -----
// Pixel transactions: accepted one per cycle while the input is not stalled; bin update is a
// 2-stage read-modify-write with forwarding in the bin memory. Finish transaction: per bin
// read, load, 17-step restoring divide, output load; the input stalls until the last bin's
// result is loaded, including any time a result waits under out_stall_i.
// Reset: asynchronous, active low; then a clearing pass zeroes the bin memory, one bin per
// cycle (LEVELS^3 bins, 64 at the default), with the input stalled.
`include "assert_macros.svh"

module rgb_color_histogram
  import rgbh_pkg::*;
#(
  parameter int LEVELS     = RGBH_LEVELS,
  parameter int COUNT_BITS = RGBH_COUNT_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [CH_W-1:0]    red_i,
  input  logic [CH_W-1:0]    green_i,
  input  logic [CH_W-1:0]    blue_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [LABEL_W-1:0] feature_label_o,
  output logic [PROP_W-1:0]  proportion_o,
  output logic               last_o
);

  localparam int NBINS  = LEVELS * LEVELS * LEVELS;
  localparam int BIN_W  = $clog2(NBINS);
  localparam int LSUM_W = (BIN_W + 1 > LABEL_W) ? BIN_W + 1 : LABEL_W;
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NBINS - 1);
  localparam logic [PROP_W-1:0] PROP_ONE = PROP_W'(1 << FRAC_BITS);

  rgbh_state_e           state_q, state_d;
  logic [BIN_W-1:0]      bin_q, bin_d;

  rgbh_op_e              mem_op;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] total;
  logic                  total_inc;
  logic                  total_clr;

  logic                  div_start;
  logic                  div_busy;
  logic [PROP_W-1:0]     div_quot;

  logic                  in_accept;
  logic                  out_free;
  logic                  out_load;
  logic                  bin_last;
  logic [LSUM_W-1:0]     label_sum;

  logic                  out_valid_q;
  logic [LABEL_W-1:0]    label_q;
  logic [PROP_W-1:0]     prop_q;
  logic                  last_q;

  // Bin memory: counts per bin, read-modify-write for pixels, read/clear for emission.
  rgbh_bin_mem #(
    .LEVELS     (LEVELS),
    .COUNT_BITS (COUNT_BITS),
    .NBINS      (NBINS),
    .BIN_W      (BIN_W)
  ) u_bin_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (mem_op),
    .red_i     (red_i),
    .green_i   (green_i),
    .blue_i    (blue_i),
    .addr_i    (bin_q),
    .rd_data_o (rd_data)
  );

  // Pixel total.
  rgbh_sat_cnt #(
    .COUNT_BITS (COUNT_BITS)
  ) u_total (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .inc_i   (total_inc),
    .clr_i   (total_clr),
    .count_o (total)
  );

  // Shared divider for count / total, one quotient bit per cycle.
  rgbh_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .count_i (rd_data),
    .total_i (total),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  // The output register may take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign bin_last   = (bin_q == LAST_BIN);
  assign label_sum  = LSUM_W'(bin_q) + LSUM_W'(1);

  always_comb begin
    state_d   = state_q;
    bin_d     = bin_q;
    mem_op    = OP_NONE;
    total_inc = 1'b0;
    total_clr = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        // Sweep the memory to zero after reset.
        mem_op = OP_CLEAR;
        if (bin_last) begin
          bin_d   = '0;
          state_d = ST_IDLE;
        end else begin
          bin_d = bin_q + BIN_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (kind_i) begin
            bin_d   = '0;
            state_d = ST_READ;
          end else begin
            mem_op    = OP_PIXEL;
            total_inc = 1'b1;
          end
        end
      end
      ST_READ: begin
        mem_op  = OP_READ;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        // Count is in the read register: start the divide and zero the bin.
        div_start = 1'b1;
        mem_op    = OP_CLEAR;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy && out_free) begin
          out_load = 1'b1;
          if (bin_last) begin
            bin_d     = '0;
            total_clr = 1'b1;
            state_d   = ST_IDLE;
          end else begin
            bin_d   = bin_q + BIN_W'(1);
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      bin_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bin_q   <= bin_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until the next load.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      label_q <= label_sum[LABEL_W-1:0];
      prop_q  <= (total == '0) ? '0 : div_quot;
      last_q  <= bin_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign feature_label_o = label_q;
  assign proportion_o    = prop_q;
  assign last_o          = last_q;

  `RGBH_ASSERT(a_prop_range, out_valid_q |-> (prop_q <= PROP_ONE), "proportion above one")
  `RGBH_ASSERT(a_div_started, (state_q == ST_WAIT) |=> div_busy, "divider not started")
  `RGBH_ASSERT(a_total_cleared, (out_load && bin_last) |=> (total == '0), "total not cleared")

endmodule

// ----- bench/rgbh_tb_pkg.sv -----
`timescale 1ns / 1ps

package rgbh_tb_pkg;

  // Kind of an input transaction.
  typedef enum logic {
    KIND_PIXEL  = 1'b0,
    KIND_FINISH = 1'b1
  } item_kind_e;

endpackage

// ----- bench/rgb_color_histogram_checker.sv -----
`timescale 1ns / 1ps

module rgb_color_histogram_checker
  import rgbh_pkg::*;
  import rgbh_tb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               kind_i,
  input  logic [CH_W-1:0]    red_i,
  input  logic [CH_W-1:0]    green_i,
  input  logic [CH_W-1:0]    blue_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [LABEL_W-1:0] feature_label_i,
  input  logic [PROP_W-1:0]  proportion_i,
  input  logic               last_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  localparam int NBINS = RGBH_LEVELS * RGBH_LEVELS * RGBH_LEVELS;
  localparam int STEP  = 255 / RGBH_LEVELS;
  localparam longint unsigned FRAC_ONE = 64'd1 << FRAC_BITS;
  localparam logic [RGBH_COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [PROP_W-1:0]  proportion;
    logic               last;
  } bin_share_t;

  logic [RGBH_COUNT_BITS-1:0] bin_count [NBINS];
  logic [RGBH_COUNT_BITS-1:0] pixel_total;
  bin_share_t                 expected_shares [$];
  int unsigned                fail_count = 0;

  assign fail_count_o = fail_count;

  function automatic int unsigned level_of(logic [CH_W-1:0] v);
    int unsigned p;
    if (v == '0) return 0;
    p = (int'(v) - 1) / STEP;
    return (p > RGBH_LEVELS - 1) ? RGBH_LEVELS - 1 : p;
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("%0t: mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
    fail_count++;
  endtask

  // Count a pixel, or turn the bins into shares and clear them on a finish.
  task automatic tally_transaction(logic kind, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                   logic [CH_W-1:0] b);
    int unsigned     idx;
    longint unsigned scaled;
    longint unsigned share;
    bin_share_t      res;
    if (kind == KIND_PIXEL) begin
      idx = (level_of(r) * RGBH_LEVELS + level_of(g)) * RGBH_LEVELS + level_of(b);
      if (bin_count[idx] != COUNT_MAX) bin_count[idx] = bin_count[idx] + 1'b1;
      if (pixel_total != COUNT_MAX) pixel_total = pixel_total + 1'b1;
    end else begin
      for (int i = 0; i < NBINS; i++) begin
        if (pixel_total == '0) begin
          share = 0;
        end else begin
          scaled = longint'(bin_count[i]) * FRAC_ONE + longint'(pixel_total) / 2;
          share  = scaled / longint'(pixel_total);
        end
        if (share > FRAC_ONE) share = FRAC_ONE;
        res.label      = LABEL_W'(i + 1);
        res.proportion = PROP_W'(share);
        res.last       = (i == NBINS - 1);
        expected_shares.push_back(res);
        bin_count[i] = '0;
      end
      pixel_total = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NBINS; i++) bin_count[i] = '0;
      pixel_total = '0;
      expected_shares.delete();
    end else begin
      if (in_valid_i && !in_stall_i) tally_transaction(kind_i, red_i, green_i, blue_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_shares.size() == 0) begin
          report_mismatch("unexpected result, label", 0, feature_label_i);
        end else begin
          if (feature_label_i !== expected_shares[0].label)
            report_mismatch("feature_label", expected_shares[0].label, feature_label_i);
          if (proportion_i !== expected_shares[0].proportion)
            report_mismatch("proportion", expected_shares[0].proportion, proportion_i);
          if (last_i !== expected_shares[0].last)
            report_mismatch("last", expected_shares[0].last, last_i);
          void'(expected_shares.pop_front());
        end
      end
    end
    pending_o = expected_shares.size();
  end

endmodule

// ----- bench/rgb_color_histogram_tb.sv -----
`timescale 1ns / 1ps

module rgb_color_histogram_tb;
  import rgbh_pkg::*;
  import rgbh_tb_pkg::*;

  // Least number of random input transactions to offer after the directed part.
  localparam int unsigned RANDOM_ITEMS = 345;
  // Results accepted before the sink takes its one long hold-off.
  localparam int unsigned LONG_HOLD_AT = 400;
  localparam int unsigned LONG_HOLD_CYCLES = 600;
  // Quiet cycles after the last result.
  localparam int unsigned DRAIN_CYCLES = 60;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               kind_i;
  logic [CH_W-1:0]    red_i;
  logic [CH_W-1:0]    green_i;
  logic [CH_W-1:0]    blue_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [LABEL_W-1:0] feature_label_o;
  logic [PROP_W-1:0]  proportion_o;
  logic               last_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent = 0;
  int unsigned quiet_items = 0;

  // Channel values on and around the quantizer thresholds, plus the clamped top.
  logic [CH_W-1:0] edge_values [19] = '{
    8'd0, 8'd1, 8'd62, 8'd63, 8'd64, 8'd65, 8'd125, 8'd126, 8'd127, 8'd128,
    8'd188, 8'd189, 8'd190, 8'd191, 8'd251, 8'd252, 8'd253, 8'd254, 8'd255
  };

  rgb_color_histogram dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .feature_label_o (feature_label_o),
    .proportion_o    (proportion_o),
    .last_o          (last_o)
  );

  // Watch both channels, predict every bin share and compare.
  rgb_color_histogram_checker bin_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .kind_i          (kind_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .feature_label_i (feature_label_o),
    .proportion_i    (proportion_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Bound the run: far beyond the slowest legal run of this stimulus.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Pick a channel value: often a threshold neighbor, otherwise anything.
  function automatic logic [CH_W-1:0] pick_channel();
    if ($urandom_range(0, 2) == 0) return edge_values[$urandom_range(0, 18)];
    return CH_W'($urandom_range(0, 255));
  endfunction

  // Offer one input transaction after a random idle gap and hold it until accepted.
  // Returns at the accepting edge, so the next call may keep valid high.
  task automatic send_item(item_kind_e kind, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                           logic [CH_W-1:0] b);
    int unsigned gap;
    if (quiet_items != 0) begin
      quiet_items--;
      gap = 0;
    end else begin
      // Now and then, run a burst with no idle cycles at all.
      if ($urandom_range(0, 24) == 0) quiet_items = $urandom_range(10, 40);
      gap = $urandom_range(0, 18);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Result sink: stall for a random number of cycles after each accepted result,
  // with quiet stretches, and one long hold-off in the middle of an emission run
  // while the sender keeps offering transactions.
  initial begin : result_sink
    int unsigned wait_left;
    int unsigned sink_quiet;
    int unsigned taken;
    int unsigned gap;
    wait_left   = 0;
    sink_quiet  = 0;
    taken       = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (wait_left != 0) begin
        wait_left--;
        if (wait_left == 0) out_stall_i <= 1'b0;
      end else if (out_valid_o && !out_stall_i) begin
        taken++;
        if (taken == LONG_HOLD_AT) begin
          gap = LONG_HOLD_CYCLES;
        end else if (sink_quiet != 0) begin
          sink_quiet--;
          gap = 0;
        end else begin
          if ($urandom_range(0, 29) == 0) sink_quiet = $urandom_range(20, 70);
          gap = $urandom_range(0, 18);
        end
        if (gap != 0) begin
          out_stall_i <= 1'b1;
          wait_left = gap;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned     npix;
    int unsigned     goal;
    bit              mono;
    logic [CH_W-1:0] base_r;
    logic [CH_W-1:0] base_g;
    logic [CH_W-1:0] base_b;

    // Drive every input from time zero; hold reset, then release it.
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    kind_i     <= KIND_PIXEL;
    red_i      <= '0;
    green_i    <= '0;
    blue_i     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: finish on an empty image twice in a row; garbage channels are ignored.
    send_item(KIND_FINISH, 8'hA5, 8'h5A, 8'hFF);
    send_item(KIND_FINISH, 8'h00, 8'hFF, 8'h81);

    // Directed: channel extremes, every threshold neighbor, and the clamped top values.
    send_item(KIND_PIXEL, 8'd0,   8'd0,   8'd0);
    send_item(KIND_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(KIND_PIXEL, 8'd1,   8'd64,  8'd127);
    send_item(KIND_PIXEL, 8'd63,  8'd126, 8'd189);
    send_item(KIND_PIXEL, 8'd64,  8'd127, 8'd190);
    send_item(KIND_PIXEL, 8'd252, 8'd253, 8'd254);
    send_item(KIND_PIXEL, 8'd255, 8'd0,   8'd128);
    send_item(KIND_PIXEL, 8'd190, 8'd189, 8'd63);
    send_item(KIND_FINISH, 8'hFF, 8'hFF, 8'hFF);

    // Directed: a single pixel owns the whole image.
    send_item(KIND_PIXEL, 8'd128, 8'd191, 8'd62);
    send_item(KIND_FINISH, 8'd0, 8'd0, 8'd0);

    // Directed: thirds, to exercise rounding of the share.
    send_item(KIND_PIXEL, 8'd0,   8'd255, 8'd0);
    send_item(KIND_PIXEL, 8'd0,   8'd253, 8'd1);
    send_item(KIND_PIXEL, 8'd255, 8'd0,   8'd255);
    send_item(KIND_FINISH, 8'h3C, 8'hC3, 8'h7E);

    // Random images: mostly short well-formed pixel runs closed by a finish,
    // some empty, some long, some single-colored.
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      case ($urandom_range(0, 9))
        0:       npix = 0;
        1:       npix = $urandom_range(40, 90);
        default: npix = $urandom_range(1, 24);
      endcase
      mono   = ($urandom_range(0, 4) == 0);
      base_r = pick_channel();
      base_g = pick_channel();
      base_b = pick_channel();
      repeat (npix) begin
        if (mono) send_item(KIND_PIXEL, base_r, base_g, base_b);
        else      send_item(KIND_PIXEL, pick_channel(), pick_channel(), pick_channel());
      end
      send_item(KIND_FINISH, CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                CH_W'($urandom_range(0, 255)));
    end

    // Drop valid, let the checker see the final transaction, then drain.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
